### hdl/npe_pkg.sv
package npe_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int ELEMENT_BITS = 32;
	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECTION = 2'd0,
		REG_SIGNED    = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic direction;
		logic signed_compare;
	} cfg_t;

	typedef struct packed {
		logic [ELEMENT_BITS-1:0] element;
		logic                    last;
		logic                    drop;
	} item_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_FIND,
		ST_SWAP,
		ST_REV_RD,
		ST_REV_MV,
		ST_REV_WR,
		ST_EMIT
	} back_state_t;

	// x goes before y in the order the direction selects
	function automatic logic goes_before(
		input logic [ELEMENT_BITS-1:0] x,
		input logic [ELEMENT_BITS-1:0] y,
		input cfg_t                    cfg
	);
		logic [ELEMENT_BITS-1:0] xa;
		logic [ELEMENT_BITS-1:0] ya;
		xa = x;
		ya = y;
		xa[ELEMENT_BITS-1] = x[ELEMENT_BITS-1] ^ cfg.signed_compare;
		ya[ELEMENT_BITS-1] = y[ELEMENT_BITS-1] ^ cfg.signed_compare;
		return cfg.direction ? (ya < xa) : (xa < ya);
	endfunction

endpackage

### hdl/npe_front.sv
module npe_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [npe_pkg::ELEMENT_BITS-1:0]  element,
	input  logic                              last_in,
	input  logic                              q_full,
	output logic                              q_push,
	output npe_pkg::item_t                    q_item
);

	logic [npe_pkg::CNT_W-1:0] fcnt_q;
	logic                      at_cap;

	// count elements of the current sequence; mark those past capacity
	assign at_cap = (fcnt_q == npe_pkg::CNT_W'(npe_pkg::MAX_ELEMENTS));
	assign full   = q_full;
	assign q_push = push && !q_full;

	assign q_item.element = element;
	assign q_item.last    = last_in;
	assign q_item.drop    = at_cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
		end else if (q_push) begin
			if (last_in) begin
				fcnt_q <= '0;
			end else if (!at_cap) begin
				fcnt_q <= fcnt_q + npe_pkg::CNT_W'(1);
			end
		end
	end

endmodule

### hdl/npe_queue.sv
module npe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  npe_pkg::item_t wr_item,
	output logic           q_full,
	input  logic           rd_en,
	output logic           rd_valid,
	output npe_pkg::item_t rd_item
);

	npe_pkg::item_t             entries_q [npe_pkg::QDEPTH];
	logic [npe_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [npe_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [npe_pkg::QCNT_W-1:0] count_q;
	logic                       do_wr;
	logic                       do_rd;

	assign q_full   = (count_q == npe_pkg::QCNT_W'(npe_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = entries_q[rd_ptr_q];
	assign do_wr    = wr_en && !q_full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + npe_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + npe_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + npe_pkg::QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - npe_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

### hdl/npe_back.sv
module npe_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  npe_pkg::cfg_t                     cfg,
	input  logic                              q_valid,
	input  npe_pkg::item_t                    q_item,
	output logic                              q_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic [npe_pkg::ELEMENT_BITS-1:0]  out_element,
	output logic                              last_out,
	output logic                              advanced,
	output logic                              overflow
);

	localparam int EB = npe_pkg::ELEMENT_BITS;
	localparam int IW = npe_pkg::IDX_W;
	localparam int CW = npe_pkg::CNT_W;

	npe_pkg::back_state_t state_q, state_nx;

	logic [EB-1:0] store_q [npe_pkg::MAX_ELEMENTS];
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic [EB-1:0] wr_data;
	logic [IW-1:0] rd_idx;
	logic [EB-1:0] rd_data;

	logic [CW-1:0] cnt_q, cnt_nx, n_new;
	logic [IW-1:0] idx_q, idx_nx;
	logic [IW-1:0] piv_idx_q, piv_idx_nx;
	logic [CW-1:0] k_q, k_nx;
	logic [CW-1:0] rlo_q, rlo_nx;
	logic [CW-1:0] rhi_q, rhi_nx;
	logic          adv_q, adv_nx;
	logic          ovf_q, ovf_nx;
	logic [EB-1:0] prev_q, prev_nx;
	logic [EB-1:0] piv_q, piv_nx;
	logic [EB-1:0] val_q, val_nx;
	logic [EB-1:0] tmp_q, tmp_nx;
	logic          emit;
	logic          emit_last;
	logic          out_valid_q;

	assign rd_data = store_q[rd_idx];
	assign n_new   = q_item.drop ? cnt_q : (cnt_q + CW'(1));

	always_comb begin
		state_nx   = state_q;
		cnt_nx     = cnt_q;
		idx_nx     = idx_q;
		piv_idx_nx = piv_idx_q;
		k_nx       = k_q;
		rlo_nx     = rlo_q;
		rhi_nx     = rhi_q;
		adv_nx     = adv_q;
		ovf_nx     = ovf_q;
		prev_nx    = prev_q;
		piv_nx     = piv_q;
		val_nx     = val_q;
		tmp_nx     = tmp_q;
		wr_en      = 1'b0;
		wr_idx     = '0;
		wr_data    = '0;
		rd_idx     = '0;
		q_pop      = 1'b0;
		emit       = 1'b0;
		emit_last  = 1'b0;
		unique case (state_q)
			npe_pkg::ST_LOAD: begin
				q_pop = q_valid;
				if (q_valid) begin
					if (q_item.drop) begin
						ovf_nx = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_idx  = cnt_q[IW-1:0];
						wr_data = q_item.element;
					end
					cnt_nx = n_new;
					if (q_item.last) begin
						if (n_new < CW'(2)) begin
							adv_nx   = 1'b0;
							k_nx     = '0;
							state_nx = npe_pkg::ST_EMIT;
						end else begin
							idx_nx   = IW'(n_new - CW'(1));
							state_nx = npe_pkg::ST_SCAN_INIT;
						end
					end
				end
			end
			npe_pkg::ST_SCAN_INIT: begin
				rd_idx   = idx_q;
				prev_nx  = rd_data;
				idx_nx   = idx_q - IW'(1);
				state_nx = npe_pkg::ST_SCAN;
			end
			npe_pkg::ST_SCAN: begin
				rd_idx = idx_q;
				if (npe_pkg::goes_before(rd_data, prev_q, cfg)) begin
					piv_idx_nx = idx_q;
					piv_nx     = rd_data;
					idx_nx     = IW'(cnt_q - CW'(1));
					state_nx   = npe_pkg::ST_FIND;
				end else begin
					prev_nx = rd_data;
					if (idx_q == '0) begin
						adv_nx   = 1'b0;
						rlo_nx   = '0;
						rhi_nx   = cnt_q;
						state_nx = npe_pkg::ST_REV_RD;
					end else begin
						idx_nx = idx_q - IW'(1);
					end
				end
			end
			npe_pkg::ST_FIND: begin
				rd_idx = idx_q;
				if (npe_pkg::goes_before(piv_q, rd_data, cfg)) begin
					wr_en    = 1'b1;
					wr_idx   = idx_q;
					wr_data  = piv_q;
					val_nx   = rd_data;
					state_nx = npe_pkg::ST_SWAP;
				end else begin
					idx_nx = idx_q - IW'(1);
				end
			end
			npe_pkg::ST_SWAP: begin
				wr_en    = 1'b1;
				wr_idx   = piv_idx_q;
				wr_data  = val_q;
				adv_nx   = 1'b1;
				rlo_nx   = CW'(piv_idx_q) + CW'(1);
				rhi_nx   = cnt_q;
				state_nx = npe_pkg::ST_REV_RD;
			end
			npe_pkg::ST_REV_RD: begin
				if ((rlo_q + CW'(1)) < rhi_q) begin
					rd_idx   = rlo_q[IW-1:0];
					tmp_nx   = rd_data;
					rhi_nx   = rhi_q - CW'(1);
					state_nx = npe_pkg::ST_REV_MV;
				end else begin
					k_nx     = '0;
					state_nx = npe_pkg::ST_EMIT;
				end
			end
			npe_pkg::ST_REV_MV: begin
				rd_idx   = rhi_q[IW-1:0];
				wr_en    = 1'b1;
				wr_idx   = rlo_q[IW-1:0];
				wr_data  = rd_data;
				state_nx = npe_pkg::ST_REV_WR;
			end
			npe_pkg::ST_REV_WR: begin
				wr_en    = 1'b1;
				wr_idx   = rhi_q[IW-1:0];
				wr_data  = tmp_q;
				rlo_nx   = rlo_q + CW'(1);
				state_nx = npe_pkg::ST_REV_RD;
			end
			npe_pkg::ST_EMIT: begin
				rd_idx = k_q[IW-1:0];
				if (!out_valid_q || pop) begin
					emit      = 1'b1;
					emit_last = ((k_q + CW'(1)) == cnt_q);
					k_nx      = k_q + CW'(1);
					if (emit_last) begin
						cnt_nx   = '0;
						ovf_nx   = 1'b0;
						state_nx = npe_pkg::ST_LOAD;
					end
				end
			end
			default: begin
				state_nx = npe_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		prev_q <= prev_nx;
		piv_q  <= piv_nx;
		val_q  <= val_nx;
		tmp_q  <= tmp_nx;
		if (emit) begin
			out_element <= rd_data;
			last_out    <= emit_last;
			advanced    <= adv_q;
			overflow    <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= npe_pkg::ST_LOAD;
			cnt_q       <= '0;
			idx_q       <= '0;
			piv_idx_q   <= '0;
			k_q         <= '0;
			rlo_q       <= '0;
			rhi_q       <= '0;
			adv_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			cnt_q     <= cnt_nx;
			idx_q     <= idx_nx;
			piv_idx_q <= piv_idx_nx;
			k_q       <= k_nx;
			rlo_q     <= rlo_nx;
			rhi_q     <= rhi_nx;
			adv_q     <= adv_nx;
			ovf_q     <= ovf_nx;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;

endmodule

### hdl/next_permutation_engine_unit.sv
// Next / previous lexicographic permutation engine.
// Input channel: drive element and last_in with push; an item is taken at a
// clock edge where push is high and full is low. A sequence ends with the
// item that carries last_in. Up to 16 elements are kept; later ones are
// dropped and flag overflow on every result of that sequence.
// Result channel: while empty is low, out_element, last_out, advanced and
// overflow show the oldest result; pop takes it. One result per stored
// element, in order, last_out on the final one.
// Configuration: cfg_we writes cfg_data[0] to register cfg_index (0 =
// direction, 1 = signed_compare); write only while the block is idle.
// Timing: the front takes one item per cycle, while the queue is not full,
// into a two-entry queue; the back stores one element per cycle while
// loading. For n >= 2 elements the back then scans for the pivot and for
// its successor, swaps them and reverses the tail pair by pair (with
// no pivot, the whole sequence), then emits one result per cycle while
// the receiver pops. While the back works, the queue fills and full rises.
// A stalled receiver holds the current result; the back waits on it.
// Reset clears counts, flags, the queue and the result valid flag; the
// element store holds no reset value and is only read where written.
module next_permutation_engine_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [npe_pkg::ELEMENT_BITS-1:0]    element,
	input  logic                                last_in,
	output logic                                empty,
	input  logic                                pop,
	output logic [npe_pkg::ELEMENT_BITS-1:0]    out_element,
	output logic                                last_out,
	output logic                                advanced,
	output logic                                overflow,
	input  logic                                cfg_we,
	input  logic [npe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [npe_pkg::CFG_DATA_W-1:0]      cfg_data
);

	npe_pkg::cfg_t  cfg_q;
	npe_pkg::item_t f_item;
	npe_pkg::item_t b_item;
	logic           f_push;
	logic           q_full;
	logic           b_valid;
	logic           b_pop;

	// hold configuration; ignore writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				npe_pkg::REG_DIRECTION: cfg_q.direction      <= cfg_data[0];
				npe_pkg::REG_SIGNED:    cfg_q.signed_compare <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// classify incoming items: mark those past capacity
	npe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.element (element),
		.last_in (last_in),
		.q_full  (q_full),
		.q_push  (f_push),
		.q_item  (f_item)
	);

	// decouple the front from the permutation sequencer
	npe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_push),
		.wr_item  (f_item),
		.q_full   (q_full),
		.rd_en    (b_pop),
		.rd_valid (b_valid),
		.rd_item  (b_item)
	);

	// store, permute and emit
	npe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (b_valid),
		.q_item      (b_item),
		.q_pop       (b_pop),
		.pop         (pop),
		.empty       (empty),
		.out_element (out_element),
		.last_out    (last_out),
		.advanced    (advanced),
		.overflow    (overflow)
	);

endmodule

### hdl/npe_checker.sv
module npe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             empty,
	input logic                             pop,
	input logic [npe_pkg::ELEMENT_BITS-1:0] out_element,
	input logic                             last_out,
	input logic                             advanced,
	input logic                             overflow
);

	// a waiting item stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_element) && $stable(last_out))
		else $error("result changed while stalled");

	// within a sequence, the next item follows the pop at once
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_out |=> !empty)
		else $error("gap inside a result sequence");

	// flags are shared by every item of one sequence
	a_adv_const: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_out |=> advanced == $past(advanced))
		else $error("advanced changed inside a sequence");

	a_ovf_const: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_out |=> overflow == $past(overflow))
		else $error("overflow changed inside a sequence");

endmodule

bind next_permutation_engine_unit npe_checker u_npe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.out_element (out_element),
	.last_out    (last_out),
	.advanced    (advanced),
	.overflow    (overflow)
);

### dv/tb_next_permutation_engine_unit.sv
`timescale 1ns / 1ps

module tb_next_permutation_engine_unit;

	localparam int SEQ_CAP = npe_pkg::MAX_ELEMENTS;

	// Indexes past the register list; writes there must change nothing.
	localparam logic [npe_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [npe_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	localparam int IDLE_PCT        = 9;
	localparam int SETTLE_CYCLES   = 80;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int RANDOM_PHASES   = 5;
	localparam int ITEMS_PER_PHASE = 48;

	// How random element values are drawn for one sequence.
	typedef enum int {
		MIX_SMALL,
		MIX_WIDE,
		MIX_BOUNDARY,
		MIX_BLEND
	} value_mix_t;

	typedef struct {
		logic [npe_pkg::ELEMENT_BITS-1:0] elem;
		logic                             last;
		logic                             adv;
		logic                             ovf;
	} perm_result_t;

	// Tracks the sequence being loaded, permutes it on the closing item and
	// queues the results the block must emit.
	class permutation_scoreboard;
		logic [npe_pkg::ELEMENT_BITS-1:0] seq[SEQ_CAP];
		int                               seq_len = 0;
		bit                               seq_dropped = 0;
		bit                               go_back = 0;
		bit                               cmp_signed = 0;
		perm_result_t                     expected_q[$];
		int                               errors = 0;
		int                               results_seen = 0;
		int                               seqs_closed = 0;
		int                               seqs_wrapped = 0;
		int                               seqs_overflowed = 0;

		function void write_reg(logic [npe_pkg::CFG_IDX_W-1:0] idx,
				logic [npe_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				npe_pkg::REG_DIRECTION: go_back = val[0];
				npe_pkg::REG_SIGNED:    cmp_signed = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// True when x sorts ahead of y in the selected direction.
		function bit ordered(logic [npe_pkg::ELEMENT_BITS-1:0] x,
				logic [npe_pkg::ELEMENT_BITS-1:0] y);
			logic [npe_pkg::ELEMENT_BITS-1:0] bias;
			logic [npe_pkg::ELEMENT_BITS-1:0] xk;
			logic [npe_pkg::ELEMENT_BITS-1:0] yk;
			bias = npe_pkg::ELEMENT_BITS'(cmp_signed) << (npe_pkg::ELEMENT_BITS - 1);
			xk = x ^ bias;
			yk = y ^ bias;
			return go_back ? (yk < xk) : (xk < yk);
		endfunction

		function void reverse_span(int lo, int hi);
			logic [npe_pkg::ELEMENT_BITS-1:0] t;
			while (lo + 1 < hi) begin
				hi--;
				t = seq[lo];
				seq[lo] = seq[hi];
				seq[hi] = t;
				lo++;
			end
		endfunction

		function bit permute_seq();
			int                               p;
			int                               q;
			logic [npe_pkg::ELEMENT_BITS-1:0] t;
			p = -1;
			for (int k = seq_len - 2; k >= 0 && p < 0; k--)
				if (ordered(seq[k], seq[k + 1]))
					p = k;
			if (p < 0) begin
				reverse_span(0, seq_len);
				return 1'b0;
			end
			q = seq_len - 1;
			while (!ordered(seq[p], seq[q]))
				q--;
			t = seq[p];
			seq[p] = seq[q];
			seq[q] = t;
			reverse_span(p + 1, seq_len);
			return 1'b1;
		endfunction

		function void note_item(logic [npe_pkg::ELEMENT_BITS-1:0] e, logic last);
			bit           adv;
			perm_result_t r;
			if (seq_len < SEQ_CAP) begin
				seq[seq_len] = e;
				seq_len++;
			end else begin
				seq_dropped = 1'b1;
			end
			if (!last)
				return;
			adv = permute_seq();
			for (int k = 0; k < seq_len; k++) begin
				r.elem = seq[k];
				r.last = (k == seq_len - 1);
				r.adv  = adv;
				r.ovf  = seq_dropped;
				expected_q.push_back(r);
			end
			seqs_closed++;
			if (!adv)
				seqs_wrapped++;
			if (seq_dropped)
				seqs_overflowed++;
			seq_len = 0;
			seq_dropped = 1'b0;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [npe_pkg::ELEMENT_BITS-1:0] e, logic l, logic a, logic o);
			perm_result_t x;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result %h arrived with nothing expected", e));
				return;
			end
			x = expected_q.pop_front();
			if (e !== x.elem)
				report_mismatch($sformatf("out_element %h, expected %h", e, x.elem));
			if (l !== x.last)
				report_mismatch($sformatf("last_out %b, expected %b", l, x.last));
			if (a !== x.adv)
				report_mismatch($sformatf("advanced %b, expected %b", a, x.adv));
			if (o !== x.ovf)
				report_mismatch($sformatf("overflow %b, expected %b", o, x.ovf));
		endtask

		task check_drained();
			if (expected_q.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
		endtask
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              push;
	logic                              full;
	logic [npe_pkg::ELEMENT_BITS-1:0]  element;
	logic                              last_in;
	logic                              empty;
	logic                              pop;
	logic [npe_pkg::ELEMENT_BITS-1:0]  out_element;
	logic                              last_out;
	logic                              advanced;
	logic                              overflow;
	logic                              cfg_we;
	logic [npe_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [npe_pkg::CFG_DATA_W-1:0]    cfg_data;

	permutation_scoreboard sb;
	int                    items_sent = 0;
	bit                    steady = 1'b0;   // set: neither side idles

	next_permutation_engine_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.element     (element),
		.last_in     (last_in),
		.empty       (empty),
		.pop         (pop),
		.out_element (out_element),
		.last_out    (last_out),
		.advanced    (advanced),
		.overflow    (overflow),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop in case the block hangs or loses results.
	initial begin
		#2_000_000;
		$display("Timeout: the block stopped making progress");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: check whatever was popped at this edge, then pick the
	// pop level for the next edge. Stall about 9% of cycles unless steady.
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(out_element, last_out, advanced, overflow);
			pop <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Offer one item and hold it until the block takes it. Idle first now
	// and then, so push gaps land on every stage of the back end's work.
	task automatic send_item(input logic [npe_pkg::ELEMENT_BITS-1:0] e, input logic l);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		element <= e;
		last_in <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_item(e, l);
		items_sent++;
	endtask

	// Drop push and hold off until every expected result has been popped.
	task automatic wait_drained();
		int guard;
		guard = 0;
		push <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (sb.pending() != 0 && guard < DRAIN_LIMIT);
	endtask

	// Write both registers plus one unused index; call only while idle.
	task automatic apply_settings(input logic dir, input logic sgn,
			input logic [npe_pkg::CFG_IDX_W-1:0] spare);
		logic junk;
		junk = 1'($urandom_range(1));
		cfg_we    <= 1'b1;
		cfg_index <= npe_pkg::REG_DIRECTION;
		cfg_data  <= dir;
		@(posedge clk);
		cfg_index <= npe_pkg::REG_SIGNED;
		cfg_data  <= sgn;
		@(posedge clk);
		cfg_index <= spare;
		cfg_data  <= junk;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(npe_pkg::REG_DIRECTION, dir);
		sb.write_reg(npe_pkg::REG_SIGNED, sgn);
		sb.write_reg(spare, junk);
	endtask

	function automatic logic [npe_pkg::ELEMENT_BITS-1:0] pick_value(value_mix_t mix);
		case (mix)
			MIX_SMALL: return npe_pkg::ELEMENT_BITS'($urandom_range(3));
			MIX_WIDE:  return $urandom();
			MIX_BOUNDARY: begin
				// values that sort differently under signed and unsigned compare
				case ($urandom_range(5))
					0:       return '0;
					1:       return '1;
					2:       return {1'b1, {(npe_pkg::ELEMENT_BITS - 1){1'b0}}};
					3:       return {1'b0, {(npe_pkg::ELEMENT_BITS - 1){1'b1}}};
					4:       return {1'b1, {(npe_pkg::ELEMENT_BITS - 2){1'b0}}, 1'b1};
					default: return npe_pkg::ELEMENT_BITS'($urandom_range(2));
				endcase
			end
			default: return $urandom_range(1) ?
				npe_pkg::ELEMENT_BITS'($urandom_range(3)) : $urandom();
		endcase
	endfunction

	// Mostly short sequences; some fill the store, some run past it.
	task automatic send_random_sequence();
		int         len;
		int         r;
		value_mix_t mix;
		r = $urandom_range(99);
		if (r < 10)
			len = 1;
		else if (r < 70)
			len = $urandom_range(6, 2);
		else if (r < 88)
			len = $urandom_range(SEQ_CAP, 7);
		else
			len = $urandom_range(SEQ_CAP + 4, SEQ_CAP + 1);
		mix = value_mix_t'($urandom_range(3));
		for (int k = 0; k < len; k++)
			send_item(pick_value(mix), k == len - 1);
	endtask

	initial begin
		int   phase;
		int   phase_start;
		logic dir;
		logic sgn;

		sb = new();
		arst_n    <= 1'b0;
		push      <= 1'b0;
		element   <= '0;
		last_in   <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= npe_pkg::REG_DIRECTION;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: forward permutation, unsigned compare.
		apply_settings(1'b0, 1'b0, REG_SPARE_LO);
		// lone element comes back unchanged, not advanced
		send_item(32'd42, 1'b1);
		// ordinary step forward
		send_item(32'd1, 1'b0);
		send_item(32'd2, 1'b0);
		send_item(32'd3, 1'b1);
		// last permutation wraps to ascending order
		send_item(32'd3, 1'b0);
		send_item(32'd2, 1'b0);
		send_item(32'd1, 1'b1);
		// field extremes, both sides of the sign bit
		send_item(32'h0000_0000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b1);
		// duplicates: equal values never count as ordered
		send_item(32'd2, 1'b0);
		send_item(32'd2, 1'b0);
		send_item(32'd1, 1'b1);
		send_item(32'd5, 1'b0);
		send_item(32'd5, 1'b1);
		send_item(32'd1, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'd2, 1'b1);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Random part: one phase per setting, the block drained between them.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin dir = 1'b1; sgn = 1'b0; end
				1: begin dir = 1'b0; sgn = 1'b1; end
				2: begin dir = 1'b1; sgn = 1'b1; end
				3: begin dir = 1'b0; sgn = 1'b0; end
				default: begin
					dir = 1'($urandom_range(1));
					sgn = 1'($urandom_range(1));
				end
			endcase
			// one phase runs back to back with no idling on either side
			steady = (phase == 2);
			apply_settings(dir, sgn, phase[0] ? REG_SPARE_HI : REG_SPARE_LO);
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				send_random_sequence();
				// now and then hold the sender until the block is empty
				if ($urandom_range(99) < 10)
					wait_drained();
			end
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
		steady = 1'b0;

		sb.check_drained();
		$display("Covered %0d sequences in %0d items: %0d wrapped, %0d overran the store.",
			sb.seqs_closed, items_sent, sb.seqs_wrapped, sb.seqs_overflowed);
		$display("Checked %0d results across both directions and both compare modes.",
			sb.results_seen);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/npe_pkg.sv
hdl/npe_front.sv
hdl/npe_queue.sv
hdl/npe_back.sv
hdl/next_permutation_engine_unit.sv
hdl/npe_checker.sv
dv/tb_next_permutation_engine_unit.sv
